// ----- rtl/core/ffss_pkg.sv -----
// Shared types and constants of the four-level fair-share scheduler.
package ffss_pkg;
  localparam int unsigned QueueDepth = 256;
  localparam int unsigned HandleBits = 16;
  localparam int unsigned PtrBits    = $clog2(QueueDepth);
  localparam int unsigned FillBits   = $clog2(QueueDepth + 1);
  localparam int unsigned AddrBits   = PtrBits + 2;
  localparam int unsigned CntBits    = 64;
  localparam int unsigned TotalBits  = 11;

  localparam logic [1:0] LvlLow    = 2'd0;
  localparam logic [1:0] LvlNormal = 2'd1;
  localparam logic [1:0] LvlHigh   = 2'd2;
  localparam logic [1:0] LvlMax    = 2'd3;

  localparam logic FuncEnq = 1'b0;
  localparam logic FuncDeq = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV1,
    ST_DIV2,
    ST_DIV3,
    ST_READ,
    ST_OUT
  } state_e;

  // Divider request and response.
  typedef struct packed {
    logic               start;
    logic [CntBits-1:0] dividend;
    logic [7:0]         divisor;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic [CntBits-1:0] quotient;
  } div_rsp_t;
endpackage

// ----- rtl/core/ffss_div.sv -----
// Radix-2 restoring divider of a 64-bit counter by an 8-bit ratio.
module ffss_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ffss_pkg::div_req_t req_i,
  output ffss_pkg::div_rsp_t rsp_o
);
  import ffss_pkg::*;

  localparam int unsigned StepBits = $clog2(CntBits + 1);

  logic [CntBits-1:0]  quo_q, quo_d;
  logic [7:0]          rem_q, rem_d;
  logic [7:0]          dvs_q, dvs_d;
  logic [StepBits-1:0] cnt_q, cnt_d;
  logic                busy_q, busy_d, done_q, done_d;
  logic [8:0]          trial;

  always_comb begin
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    trial  = {rem_q, quo_q[CntBits-1]};
    if (req_i.start) begin
      quo_d  = req_i.dividend;
      rem_d  = '0;
      dvs_d  = req_i.divisor;
      cnt_d  = StepBits'(CntBits);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = 8'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[CntBits-2:0], 1'b1};
      end else begin
        rem_d = trial[7:0];
        quo_d = {quo_q[CntBits-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == StepBits'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;
endmodule

// ----- rtl/core/ffss_store.sv -----
// Handle memory for all four queues, one write and one registered read port.
module ffss_store (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [ffss_pkg::AddrBits-1:0]   waddr_i,
  input  logic [ffss_pkg::HandleBits-1:0] wdata_i,
  input  logic [ffss_pkg::AddrBits-1:0]   raddr_i,
  output logic [ffss_pkg::HandleBits-1:0] rdata_o
);
  import ffss_pkg::*;

  logic [HandleBits-1:0] mem [4*QueueDepth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule

// ----- rtl/core/four_level_fair_share_scheduler.sv -----
// Top level of the four-level fair-share scheduler.
//   channel | valid     | stall     | payload
//   in      | in_valid_i| in_stall_o| func_i, actor_handle_i, level_i
//   out     | out_valid_o| out_stall_i| done_res_o, popped_handle_o, popped_level_o,
//           |           |           | total_queued_o
//   config  | APB psel/penable/pwrite/paddr/pwdata, prdata, pready
// An enqueue result is registered and valid in the cycle after the transfer; a dequeue from max, or from high
// with normal and low empty, goes straight to one memory read. Any other dequeue first runs
// three bit-serial 64-step divisions in one shared divider (the high dequeue counter, that
// quotient, then the normal dequeue counter), then one memory read if a level is picked. One
// item is in flight at a time; the result sits in an output register and a new item is taken
// once it is transferred. Reset clears pointers, fill counts, counters and sets share_ratio
// to 2; the handle memory is not cleared.
module four_level_fair_share_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        func_i,
  input  logic [15:0] actor_handle_i,
  input  logic [1:0]  level_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        done_res_o,
  output logic [15:0] popped_handle_o,
  output logic [1:0]  popped_level_o,
  output logic [10:0] total_queued_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ffss_pkg::*;

  state_e state_q, state_d;
  logic [7:0]          ratio_q;
  logic [PtrBits-1:0]  head_q [4];
  logic [PtrBits-1:0]  tail_q [4];
  logic [FillBits-1:0] fill_q [4];
  logic [CntBits-1:0]  cnt_q  [4];
  logic [CntBits-1:0]  an_q, an_d, al_q, al_d;
  logic [1:0]          sel_q, sel_d;
  logic                ovalid_q, odone_q;
  logic [1:0]          olvl_q;
  logic [HandleBits-1:0] ohandle_q;
  logic [TotalBits-1:0] total_q;
  logic                opop_q;

  div_req_t div_req;
  div_rsp_t div_rsp;
  logic [7:0] r_eff;
  logic       accept, can_take, enq_ok, deq_ok;
  logic       we;
  logic [AddrBits-1:0] waddr, raddr;
  logic [HandleBits-1:0] rdata;
  logic       lo_e, no_e, hi_e, mx_e;
  logic [1:0] pick_late;
  logic [TotalBits-1:0] total_next;

  assign pready     = 1'b1;
  assign prdata     = {24'd0, ratio_q};
  assign r_eff      = (ratio_q == 8'd0) ? 8'd1 : ratio_q;
  assign can_take   = (state_q == ST_IDLE) && !(ovalid_q && out_stall_i);
  assign in_stall_o = !can_take;
  assign accept     = in_valid_i && can_take;

  assign mx_e = fill_q[LvlMax]    == '0;
  assign hi_e = fill_q[LvlHigh]   == '0;
  assign no_e = fill_q[LvlNormal] == '0;
  assign lo_e = fill_q[LvlLow]    == '0;

  assign enq_ok = fill_q[level_i] != FillBits'(QueueDepth);

  ffss_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign we    = accept && func_i == FuncEnq && enq_ok;
  assign waddr = {level_i, tail_q[level_i]};
  assign raddr = {sel_q, head_q[sel_q]};

  ffss_store u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (actor_handle_i),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Whether the dequeue can pop any level, from the fill counts and the first two quotients.
  function automatic logic pick_ok_next();
    return !(no_e && lo_e) || (!hi_e && cnt_q[LvlNormal] >= an_q
           && cnt_q[LvlLow] >= al_q);
  endfunction

  // Late pick uses the freshly loaded third quotient.
  always_comb begin
    priority if (!hi_e && cnt_q[LvlNormal] >= an_q && cnt_q[LvlLow] >= al_q)
      pick_late = LvlHigh;
    else if (lo_e) pick_late = LvlNormal;
    else if (no_e) pick_late = LvlLow;
    else if (cnt_q[LvlLow] < div_rsp.quotient) pick_late = LvlLow;
    else pick_late = LvlNormal;
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && func_i == FuncDeq) begin
          priority if (!mx_e) state_d = ST_READ;
          else if (!hi_e && no_e && lo_e) state_d = ST_READ;
          else state_d = ST_DIV1;
        end
      end
      ST_DIV1: if (div_rsp.done) state_d = ST_DIV2;
      ST_DIV2: if (div_rsp.done) state_d = ST_DIV3;
      ST_DIV3: if (div_rsp.done) state_d = pick_ok_next() ? ST_READ : ST_OUT;
      ST_READ: state_d = ST_OUT;
      ST_OUT:  state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer: divider requests, operand capture and the level select.
  always_comb begin
    div_req = '0;
    an_d = an_q;
    al_d = al_q;
    sel_d = sel_q;
    div_req.divisor = r_eff;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && func_i == FuncDeq) begin
          sel_d = mx_e ? LvlHigh : LvlMax;
          div_req.start    = 1'b1;
          div_req.dividend = cnt_q[LvlHigh];
        end
      end
      ST_DIV1: if (div_rsp.done) begin
        an_d = div_rsp.quotient;
        div_req.start    = 1'b1;
        div_req.dividend = div_rsp.quotient;
      end
      ST_DIV2: if (div_rsp.done) begin
        al_d = div_rsp.quotient;
        div_req.start    = 1'b1;
        div_req.dividend = cnt_q[LvlNormal];
      end
      ST_DIV3: if (div_rsp.done) begin
        sel_d = pick_late;
      end
      default: ;
    endcase
  end

  always_comb begin
    total_next = TotalBits'(fill_q[0]) + TotalBits'(fill_q[1])
               + TotalBits'(fill_q[2]) + TotalBits'(fill_q[3]);
  end

  assign deq_ok = state_q == ST_READ;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      ratio_q   <= 8'd2;
      ovalid_q  <= 1'b0;
      odone_q   <= 1'b0;
      olvl_q    <= '0;
      ohandle_q <= '0;
      opop_q    <= 1'b0;
      total_q   <= '0;
      sel_q     <= '0;
      for (int i = 0; i < 4; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        fill_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else begin
      state_q <= state_d;
      sel_q   <= sel_d;
      if (psel && penable && pwrite && pready && paddr == 1'b0) begin
        ratio_q <= pwdata[7:0];
      end
      if ((accept && func_i == FuncEnq) || state_q == ST_OUT) begin
        ovalid_q <= 1'b1;
      end else if (!out_stall_i) begin
        ovalid_q <= 1'b0;
      end
      if (accept && func_i == FuncEnq) begin
        if (enq_ok) begin
          tail_q[level_i] <= tail_q[level_i] + 1'b1;
          fill_q[level_i] <= fill_q[level_i] + 1'b1;
        end
        odone_q   <= enq_ok;
        olvl_q    <= '0;
        ohandle_q <= '0;
        total_q   <= total_next + TotalBits'(enq_ok);
      end else if (state_q == ST_OUT) begin
        // rdata holds the handle read in the memory read cycle.
        odone_q   <= opop_q;
        olvl_q    <= opop_q ? sel_q : 2'd0;
        ohandle_q <= opop_q ? rdata : '0;
        total_q   <= total_next;
      end
      if (deq_ok) begin
        head_q[sel_q] <= head_q[sel_q] + 1'b1;
        fill_q[sel_q] <= fill_q[sel_q] - 1'b1;
        cnt_q[sel_q]  <= cnt_q[sel_q] + 1'b1;
      end
      opop_q <= deq_ok ? 1'b1 : (state_q == ST_OUT ? 1'b0 : opop_q);
    end
  end

  assign out_valid_o     = ovalid_q;
  assign done_res_o      = odone_q;
  assign popped_level_o  = olvl_q;
  assign popped_handle_o = ohandle_q;
  assign total_queued_o  = total_q;

  always_ff @(posedge clk_i) begin
    an_q <= an_d;
    al_q <= al_d;
  end
endmodule

// ----- tb/tb_top.sv -----
// Testbench for the four-level fair-share scheduler: directed and random traffic against a queue model.
module tb_top;
  import ffss_pkg::*;

  class sched_scoreboard;
    logic [15:0] store[4][$];
    logic [63:0] deq_cnt[4];
    logic [7:0]  ratio;
    logic        exp_done[$];
    logic [15:0] exp_handle[$];
    logic [1:0]  exp_level[$];
    logic [10:0] exp_total[$];
    int          errors;

    function new();
      for (int i = 0; i < 4; i++) deq_cnt[i] = '0;
      ratio  = 8'd2;
      errors = 0;
    endfunction

    function int unsigned pending();
      return exp_done.size();
    endfunction

    function logic [1:0] pick_level(output logic any);
      logic [63:0] r, an, al;
      int lo, no, hi;
      r  = (ratio == 0) ? 64'd1 : {56'd0, ratio};
      lo = store[LvlLow].size();
      no = store[LvlNormal].size();
      hi = store[LvlHigh].size();
      any = 1'b1;
      if (store[LvlMax].size() > 0) return LvlMax;
      if (hi > 0 && lo == 0 && no == 0) return LvlHigh;
      an = deq_cnt[LvlHigh] / r;
      al = an / r;
      if (hi > 0 && deq_cnt[LvlNormal] >= an && deq_cnt[LvlLow] >= al) return LvlHigh;
      if (no == 0 && lo == 0) begin
        any = 1'b0;
        return LvlLow;
      end
      if (lo == 0) return LvlNormal;
      if (no == 0) return LvlLow;
      if (deq_cnt[LvlLow] < deq_cnt[LvlNormal] / r) return LvlLow;
      return LvlNormal;
    endfunction

    function void note_transfer(logic func, logic [15:0] handle, logic [1:0] lvl);
      logic        done, any;
      logic [15:0] ph;
      logic [1:0]  pl, sel;
      done = 1'b0;
      ph   = '0;
      pl   = '0;
      if (func == FuncEnq) begin
        if (store[lvl].size() < QueueDepth) begin
          store[lvl].push_back(handle);
          done = 1'b1;
        end
      end else begin
        sel = pick_level(any);
        if (any && store[sel].size() > 0) begin
          ph = store[sel].pop_front();
          deq_cnt[sel]++;
          done = 1'b1;
          pl = sel;
        end
      end
      exp_done.push_back(done);
      exp_handle.push_back(ph);
      exp_level.push_back(pl);
      exp_total.push_back(11'(store[0].size() + store[1].size() + store[2].size()
                              + store[3].size()));
    endfunction

    function void check_result(logic done, logic [15:0] ph, logic [1:0] pl, logic [10:0] tot);
      logic [10:0] t;
      if (exp_done.size() == 0) begin
        $error("unexpected result done=%0d handle=%0h", done, ph);
        errors++;
        return;
      end
      if (exp_done[0] !== done) begin
        $error("done_res: expected %0d actual %0d", exp_done[0], done);
        errors++;
      end
      if (exp_handle[0] !== ph) begin
        $error("popped_handle: expected %0h actual %0h", exp_handle[0], ph);
        errors++;
      end
      if (exp_level[0] !== pl) begin
        $error("popped_level: expected %0d actual %0d", exp_level[0], pl);
        errors++;
      end
      t = exp_total[0];
      if (t !== tot) begin
        $error("total_queued: expected %0d actual %0d", t, tot);
        errors++;
      end
      void'(exp_done.pop_front());
      void'(exp_handle.pop_front());
      void'(exp_level.pop_front());
      void'(exp_total.pop_front());
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        func_i = 1'b0;
  logic [15:0] actor_handle_i = '0;
  logic [1:0]  level_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        done_res_o;
  logic [15:0] popped_handle_o;
  logic [1:0]  popped_level_o;
  logic [10:0] total_queued_o;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0, paddr = 1'b0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  sched_scoreboard sb = new();
  bit          calm;
  bit          hold_out;
  int          idle_cycles;

  always #5 clk_i = ~clk_i;

  four_level_fair_share_scheduler u_dut (.*);

  // Check results and drive random output stalls.
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i)
        sb.check_result(done_res_o, popped_handle_o, popped_level_o, total_queued_o);
      if (burst > 0) begin
        burst--;
        out_stall_i <= 1'b1;
      end else if (!calm && !hold_out && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 16) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Watchdog: count cycles with no transfer on the in or out channel and no config access.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 4000) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_ratio(logic [7:0] val);
    @(posedge clk_i);
    psel   <= 1'b1;
    pwrite <= 1'b1;
    paddr  <= 1'b0;
    pwdata <= {24'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.ratio = val;
  endtask

  // Valid stays high between back-to-back items; drop it only while idling.
  task automatic send_item(logic func, logic [15:0] handle, logic [1:0] lvl);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    func_i         <= func;
    actor_handle_i <= handle;
    level_i        <= lvl;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_transfer(func, handle, lvl);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  // Enqueue-heavy or dequeue-heavy random traffic.
  task automatic random_phase(int n, int enq_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < enq_pct)
        send_item(FuncEnq, 16'($urandom), 2'($urandom));
      else
        send_item(FuncDeq, 16'($urandom), 2'($urandom));
    end
  endtask

  initial begin
    idle_cycles = 0;
    calm = 0;
    hold_out = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    // Directed: dequeue while all empty, extremes of handles and levels.
    send_item(FuncDeq, 16'hFFFF, LvlMax);
    send_item(FuncEnq, 16'h0000, LvlLow);
    send_item(FuncEnq, 16'hFFFF, LvlNormal);
    send_item(FuncEnq, 16'hA5A5, LvlHigh);
    send_item(FuncEnq, 16'h5A5A, LvlMax);
    send_item(FuncEnq, 16'h1234, LvlHigh);
    repeat (6) send_item(FuncDeq, 16'($urandom), 2'($urandom));
    drain();
    // Full queue: fill max level past its depth, then empty it.
    for (int i = 0; i < QueueDepth + 1; i++) send_item(FuncEnq, 16'(i), LvlMax);
    for (int i = 0; i < QueueDepth + 1; i++) send_item(FuncDeq, 16'h0, LvlLow);
    drain();
    // Zero ratio acts as one.
    write_ratio(8'd0);
    random_phase(20, 60);
    drain();
    write_ratio(8'd255);
    random_phase(20, 55);
    drain();
    write_ratio(8'd1);
    random_phase(20, 50);
    drain();
    write_ratio(8'($urandom_range(2, 6)));
    random_phase(20, 55);
    calm = 1;
    random_phase(16, 45);
    drain();
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end
endmodule
